[rtl/core/sipj_pkg.sv]
// Shared types and constants of the sorted interval / point join core.
`timescale 1ns / 1ps

package sipj_pkg;

    localparam int KIND_W  = 2;
    localparam int FIELD_W = 32;
    localparam int IDX_W   = 12;
    localparam int MOTIF_W = 10;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD      = 2'd0,
        KIND_QUERY     = 2'd1,
        KIND_NEW_CHROM = 2'd2,
        KIND_CLEAR_CNT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_SKIP,
        ST_EMIT,
        ST_OVF
    } state_t;

endpackage

[rtl/core/sipj_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sipj_ram #(
    parameter int DEPTH = 1024,
    parameter int DW    = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/sorted_interval_point_join_core.sv]
// Top level of the sorted interval / point overlap join core.
//
// Request channel (req_valid / req_ready): kind selects load point, query
// interval, new chromosome or clear counts. Result channel (res_valid /
// res_ready) carries one result per hit point (at most MAX_HITS per query), a
// single no-hit result for a query without hits, and one for a dropped load.
// Requests are taken one at a time; req_ready is high while the core is idle.
// Load, new chromosome: taken when idle; a dropped load then sends its result
// from the overflow state. Clear counts: the request is taken, then one count
// table entry per cycle is cleared over all NUM_MOTIFS entries. Query: setup
// takes the request, reads the count table and makes the final start compare;
// the scan then steps past the points below the interval start and over the
// emitted points through the single read port of the point store. The first
// result of a query leaves about one point later than its compare, since the
// last flag needs the next point. After reset the core runs the same clearing
// pass over the count table before it takes a request. A result waits in the
// output register while res_ready is low; the scan holds until that register
// frees, and a new request is still taken while a final result waits.
`timescale 1ns / 1ps

module sorted_interval_point_join_core #(
    parameter int MAX_POINTS = 4096,
    parameter int NUM_MOTIFS = 1024,
    parameter int MAX_HITS   = 64,
    parameter int COORD_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [sipj_pkg::KIND_W-1:0]     kind,
    input  logic [sipj_pkg::FIELD_W-1:0]    point_coord,
    input  logic [sipj_pkg::FIELD_W-1:0]    interval_begin,
    input  logic [sipj_pkg::FIELD_W-1:0]    interval_end,
    input  logic [sipj_pkg::MOTIF_W-1:0]    motif_id,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic                            hit,
    output logic [sipj_pkg::IDX_W-1:0]      point_index,
    output logic [sipj_pkg::FIELD_W-1:0]    point_coord_out,
    output logic [sipj_pkg::MOTIF_W-1:0]    motif_out,
    output logic [sipj_pkg::FIELD_W-1:0]    motif_hits,
    output logic                            last,
    output logic                            truncated,
    output logic                            load_overflow
);

    localparam int CW  = (COORD_BITS < sipj_pkg::FIELD_W) ? COORD_BITS : sipj_pkg::FIELD_W;
    localparam int PAW = $clog2(MAX_POINTS);
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int MAW = $clog2(NUM_MOTIFS);
    localparam int HW  = $clog2(MAX_HITS + 1);
    localparam int FW  = sipj_pkg::FIELD_W;
    localparam int IW  = sipj_pkg::IDX_W;
    localparam int MW  = sipj_pkg::MOTIF_W;

    sipj_pkg::state_t state_reg, state_next;

    logic [PCW-1:0] count_reg, count_next;
    logic [PCW-1:0] ptr_reg, ptr_next;
    logic [PCW-1:0] pos_reg, pos_next;
    logic [HW-1:0]  n_reg, n_next;
    logic [FW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  lo_reg, lo_next;
    logic [CW-1:0]  hi_reg, hi_next;
    logic [MW-1:0]  motif_reg, motif_next;
    logic           in_tab_reg, in_tab_next;
    logic [MAW-1:0] clr_reg, clr_next;

    logic           pend_valid_reg, pend_valid_next;
    logic [PCW-1:0] pend_idx_reg, pend_idx_next;
    logic [CW-1:0]  pend_coord_reg, pend_coord_next;
    logic [FW-1:0]  pend_hits_reg, pend_hits_next;

    logic           res_valid_reg, res_valid_next;
    logic           res_hit_reg, res_hit_next;
    logic [IW-1:0]  res_idx_reg, res_idx_next;
    logic [FW-1:0]  res_coord_reg, res_coord_next;
    logic [MW-1:0]  res_motif_reg, res_motif_next;
    logic [FW-1:0]  res_hits_reg, res_hits_next;
    logic           res_last_reg, res_last_next;
    logic           res_trunc_reg, res_trunc_next;
    logic           res_ovf_reg, res_ovf_next;

    logic           pt_wr_en;
    logic [PAW-1:0] pt_rd_addr;
    logic [CW-1:0]  pt_rd_data;
    logic           tab_wr_en;
    logic [MAW-1:0] tab_wr_addr;
    logic [FW-1:0]  tab_wr_data;
    logic [MAW-1:0] tab_rd_addr;
    logic [FW-1:0]  tab_rd_data;

    logic              res_free;
    logic              hit_cond;
    logic              take;
    logic [FW-1:0]     cnt_inc;
    logic [PCW+IW-1:0] pend_idx_ext;
    logic [CW+FW-1:0]  pend_coord_ext;
    logic [MAW+MW-1:0] motif_reg_ext;
    logic [MAW+MW-1:0] motif_in_ext;

    assign motif_reg_ext  = {{MAW{1'b0}}, motif_reg};
    assign motif_in_ext   = {{MAW{1'b0}}, motif_id};
    assign pend_idx_ext   = {{IW{1'b0}}, pend_idx_reg};
    assign pend_coord_ext = {{FW{1'b0}}, pend_coord_reg};
    assign tab_rd_addr    = motif_in_ext[MAW-1:0];

    sipj_ram #(
        .DEPTH (MAX_POINTS),
        .DW    (CW),
        .AW    (PAW)
    ) u_point_ram (
        .clk     (clk),
        .wr_en   (pt_wr_en),
        .wr_addr (count_reg[PAW-1:0]),
        .wr_data (point_coord[CW-1:0]),
        .rd_addr (pt_rd_addr),
        .rd_data (pt_rd_data)
    );

    sipj_ram #(
        .DEPTH (NUM_MOTIFS),
        .DW    (FW),
        .AW    (MAW)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (tab_wr_en),
        .wr_addr (tab_wr_addr),
        .wr_data (tab_wr_data),
        .rd_addr (tab_rd_addr),
        .rd_data (tab_rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        cnt_next        = cnt_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        motif_next      = motif_reg;
        in_tab_next     = in_tab_reg;
        clr_next        = clr_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_coord_next = pend_coord_reg;
        pend_hits_next  = pend_hits_reg;
        res_valid_next  = res_valid_reg;
        res_hit_next    = res_hit_reg;
        res_idx_next    = res_idx_reg;
        res_coord_next  = res_coord_reg;
        res_motif_next  = res_motif_reg;
        res_hits_next   = res_hits_reg;
        res_last_next   = res_last_reg;
        res_trunc_next  = res_trunc_reg;
        res_ovf_next    = res_ovf_reg;

        req_ready   = (state_reg == sipj_pkg::ST_IDLE);
        res_free    = !res_valid_reg || res_ready;
        pt_wr_en    = 1'b0;
        tab_wr_en   = 1'b0;
        tab_wr_addr = motif_reg_ext[MAW-1:0];
        tab_wr_data = cnt_reg;

        hit_cond = (pos_reg < count_reg) && (pt_rd_data <= hi_reg);
        take     = hit_cond && (n_reg < HW'(MAX_HITS));
        if (in_tab_reg && (cnt_reg != {FW{1'b1}}))
        begin
            cnt_inc = cnt_reg + FW'(1);
        end
        else
        begin
            cnt_inc = cnt_reg;
        end

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            sipj_pkg::ST_CLEAR:
            begin
                tab_wr_en   = 1'b1;
                tab_wr_addr = clr_reg;
                tab_wr_data = '0;
                clr_next    = clr_reg + MAW'(1);
                if (clr_reg == MAW'(NUM_MOTIFS - 1))
                begin
                    clr_next   = '0;
                    state_next = sipj_pkg::ST_IDLE;
                end
            end

            sipj_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (sipj_pkg::kind_t'(kind))
                        sipj_pkg::KIND_LOAD:
                        begin
                            if (count_reg >= PCW'(MAX_POINTS))
                            begin
                                state_next = sipj_pkg::ST_OVF;
                            end
                            else
                            begin
                                pt_wr_en   = 1'b1;
                                count_next = count_reg + PCW'(1);
                            end
                        end
                        sipj_pkg::KIND_QUERY:
                        begin
                            lo_next     = interval_begin[CW-1:0];
                            hi_next     = interval_end[CW-1:0];
                            motif_next  = motif_id;
                            in_tab_next = (FW'(motif_id) < FW'(NUM_MOTIFS));
                            if (ptr_reg > count_reg)
                            begin
                                ptr_next = count_reg;
                            end
                            state_next = sipj_pkg::ST_FETCH;
                        end
                        sipj_pkg::KIND_NEW_CHROM:
                        begin
                            count_next = '0;
                            ptr_next   = '0;
                        end
                        sipj_pkg::KIND_CLEAR_CNT:
                        begin
                            state_next = sipj_pkg::ST_CLEAR;
                        end
                    endcase
                end
            end

            sipj_pkg::ST_FETCH:
            begin
                cnt_next   = in_tab_reg ? tab_rd_data : '0;
                state_next = sipj_pkg::ST_SKIP;
            end

            sipj_pkg::ST_SKIP:
            begin
                // advance past points below the interval start
                if ((ptr_reg < count_reg) && (pt_rd_data < lo_reg))
                begin
                    ptr_next = ptr_reg + PCW'(1);
                end
                else
                begin
                    pos_next        = ptr_reg;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    state_next      = sipj_pkg::ST_EMIT;
                end
            end

            sipj_pkg::ST_EMIT:
            begin
                if (res_free)
                begin
                    if (take)
                    begin
                        // release the held hit, it is not the last one
                        if (pend_valid_reg)
                        begin
                            res_valid_next = 1'b1;
                            res_hit_next   = 1'b1;
                            res_idx_next   = pend_idx_ext[IW-1:0];
                            res_coord_next = pend_coord_ext[FW-1:0];
                            res_motif_next = motif_reg;
                            res_hits_next  = pend_hits_reg;
                            res_last_next  = 1'b0;
                            res_trunc_next = 1'b0;
                            res_ovf_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = pos_reg;
                        pend_coord_next = pt_rd_data;
                        pend_hits_next  = cnt_inc;
                        cnt_next        = cnt_inc;
                        n_next          = n_reg + HW'(1);
                        pos_next        = pos_reg + PCW'(1);
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                        res_motif_next = motif_reg;
                        res_last_next  = 1'b1;
                        res_ovf_next   = 1'b0;
                        if (pend_valid_reg)
                        begin
                            res_hit_next   = 1'b1;
                            res_idx_next   = pend_idx_ext[IW-1:0];
                            res_coord_next = pend_coord_ext[FW-1:0];
                            res_hits_next  = pend_hits_reg;
                            res_trunc_next = hit_cond;
                        end
                        else
                        begin
                            res_hit_next   = 1'b0;
                            res_idx_next   = '0;
                            res_coord_next = '0;
                            res_hits_next  = cnt_reg;
                            res_trunc_next = 1'b0;
                        end
                        pend_valid_next = 1'b0;
                        tab_wr_en       = in_tab_reg;
                        state_next      = sipj_pkg::ST_IDLE;
                    end
                end
            end

            sipj_pkg::ST_OVF:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_hit_next   = 1'b0;
                    res_idx_next   = '0;
                    res_coord_next = '0;
                    res_motif_next = '0;
                    res_hits_next  = '0;
                    res_last_next  = 1'b1;
                    res_trunc_next = 1'b0;
                    res_ovf_next   = 1'b1;
                    state_next     = sipj_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sipj_pkg::ST_IDLE;
            end
        endcase

        // the point store read follows whichever pointer the scan uses next
        if (state_next == sipj_pkg::ST_EMIT)
        begin
            pt_rd_addr = pos_next[PAW-1:0];
        end
        else
        begin
            pt_rd_addr = ptr_next[PAW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sipj_pkg::ST_CLEAR;
            count_reg      <= '0;
            ptr_reg        <= '0;
            pos_reg        <= '0;
            n_reg          <= '0;
            clr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            pos_reg        <= pos_next;
            n_reg          <= n_next;
            clr_reg        <= clr_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        motif_reg      <= motif_next;
        in_tab_reg     <= in_tab_next;
        pend_idx_reg   <= pend_idx_next;
        pend_coord_reg <= pend_coord_next;
        pend_hits_reg  <= pend_hits_next;
        res_hit_reg    <= res_hit_next;
        res_idx_reg    <= res_idx_next;
        res_coord_reg  <= res_coord_next;
        res_motif_reg  <= res_motif_next;
        res_hits_reg   <= res_hits_next;
        res_last_reg   <= res_last_next;
        res_trunc_reg  <= res_trunc_next;
        res_ovf_reg    <= res_ovf_next;
    end

    assign res_valid       = res_valid_reg;
    assign hit             = res_hit_reg;
    assign point_index     = res_idx_reg;
    assign point_coord_out = res_coord_reg;
    assign motif_out       = res_motif_reg;
    assign motif_hits      = res_hits_reg;
    assign last            = res_last_reg;
    assign truncated       = res_trunc_reg;
    assign load_overflow   = res_ovf_reg;

endmodule

[tb/tb_sorted_interval_point_join_core.sv]
// Self-checking testbench for the sorted interval / point overlap join core.
`timescale 1ns / 1ps

module tb_sorted_interval_point_join_core;

    localparam int KIND_W        = sipj_pkg::KIND_W;
    localparam int FIELD_W       = sipj_pkg::FIELD_W;
    localparam int IDX_W         = sipj_pkg::IDX_W;
    localparam int MOTIF_W       = sipj_pkg::MOTIF_W;
    localparam int MAX_POINTS    = 4096;
    localparam int NUM_MOTIFS    = 1024;
    localparam int MAX_HITS      = 64;
    localparam int STUCK_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 1200;
    localparam int RANDOM_REQS   = 12;
    localparam int HOLD_OFF      = 300;

    typedef struct packed {
        logic               hit;
        logic [IDX_W-1:0]   idx;
        logic [FIELD_W-1:0] coord;
        logic [MOTIF_W-1:0] motif;
        logic [FIELD_W-1:0] count;
        logic               is_last;
        logic               trunc;
        logic               ovf;
    } join_result_t;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               req_valid      = 1'b0;
    logic               req_ready;
    logic [KIND_W-1:0]  kind           = '0;
    logic [FIELD_W-1:0] point_coord    = '0;
    logic [FIELD_W-1:0] interval_begin = '0;
    logic [FIELD_W-1:0] interval_end   = '0;
    logic [MOTIF_W-1:0] motif_id       = '0;
    logic               res_valid;
    logic               res_ready      = 1'b0;
    logic               hit;
    logic [IDX_W-1:0]   point_index;
    logic [FIELD_W-1:0] point_coord_out;
    logic [MOTIF_W-1:0] motif_out;
    logic [FIELD_W-1:0] motif_hits;
    logic               last;
    logic               truncated;
    logic               load_overflow;

    // Shadow copy of the core state
    logic [FIELD_W-1:0] shadow_points [MAX_POINTS];
    logic [FIELD_W-1:0] shadow_motif_hits [NUM_MOTIFS];
    int unsigned        shadow_count = 0;
    int unsigned        shadow_scan  = 0;

    join_result_t expected_hits[$];
    int unsigned  mismatches  = 0;
    int unsigned  reqs_sent   = 0;
    int unsigned  hold_cycles = 0;
    bit           idle_on     = 1'b1;
    int unsigned  stuck       = 0;

    sorted_interval_point_join_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .kind            (kind),
        .point_coord     (point_coord),
        .interval_begin  (interval_begin),
        .interval_end    (interval_end),
        .motif_id        (motif_id),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .hit             (hit),
        .point_index     (point_index),
        .point_coord_out (point_coord_out),
        .motif_out       (motif_out),
        .motif_hits      (motif_hits),
        .last            (last),
        .truncated       (truncated),
        .load_overflow   (load_overflow)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
    endtask

    task automatic wipe_motif_counts();
        for (int i = 0; i < NUM_MOTIFS; i++)
            shadow_motif_hits[i] = '0;
    endtask

    // Append one expected result at the tail of the queue
    task automatic queue_expected(input join_result_t r);
        expected_hits = {expected_hits, r};
    endtask

    function automatic join_result_t make_result(input logic h, input int unsigned pos,
                                                 input logic [FIELD_W-1:0] c,
                                                 input logic [MOTIF_W-1:0] m,
                                                 input logic [FIELD_W-1:0] cnt,
                                                 input logic lst, input logic tr,
                                                 input logic ov);
        join_result_t r;
        r.hit     = h;
        r.idx     = IDX_W'(pos);
        r.coord   = c;
        r.motif   = m;
        r.count   = cnt;
        r.is_last = lst;
        r.trunc   = tr;
        r.ovf     = ov;
        return r;
    endfunction

    // Sweep-line join on the shadow state; queues the results one request causes
    task automatic predict_join(input sipj_pkg::kind_t k, input logic [FIELD_W-1:0] pc,
                                input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi,
                                input logic [MOTIF_W-1:0] m);
        int unsigned pos;
        int          n;
        bit          more;
        case (k)
            sipj_pkg::KIND_LOAD:
            begin
                if (shadow_count >= MAX_POINTS)
                    queue_expected(make_result(1'b0, 0, '0, '0, '0, 1'b1, 1'b0, 1'b1));
                else
                begin
                    shadow_points[shadow_count] = pc;
                    shadow_count++;
                end
            end
            sipj_pkg::KIND_NEW_CHROM:
            begin
                shadow_count = 0;
                shadow_scan  = 0;
            end
            sipj_pkg::KIND_CLEAR_CNT:
                wipe_motif_counts();
            default:
            begin
                if (shadow_scan > shadow_count)
                    shadow_scan = shadow_count;
                while (shadow_scan < shadow_count && shadow_points[shadow_scan] < lo)
                    shadow_scan++;
                pos = shadow_scan;
                n   = 0;
                while (n < MAX_HITS && pos < shadow_count && shadow_points[pos] <= hi)
                begin
                    if (shadow_motif_hits[m] != '1)
                        shadow_motif_hits[m] = shadow_motif_hits[m] + 1;
                    n++;
                    more = (pos + 1 < shadow_count) && (shadow_points[pos + 1] <= hi);
                    // last on the final emitted point; truncated if one more was in range
                    queue_expected(make_result(1'b1, pos, shadow_points[pos], m,
                                               shadow_motif_hits[m],
                                               !(more && n < MAX_HITS),
                                               more && n == MAX_HITS, 1'b0));
                    pos++;
                end
                if (n == 0)
                    queue_expected(make_result(1'b0, 0, '0, m, shadow_motif_hits[m],
                                               1'b1, 1'b0, 1'b0));
            end
        endcase
    endtask

    task automatic send_req(input sipj_pkg::kind_t k, input logic [FIELD_W-1:0] pc,
                            input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi,
                            input logic [MOTIF_W-1:0] m);
        req_valid      <= 1'b1;
        kind           <= k;
        point_coord    <= pc;
        interval_begin <= lo;
        interval_end   <= hi;
        motif_id       <= m;
        do @(posedge clk); while (!req_ready);
        predict_join(k, pc, lo, hi, m);
        reqs_sent++;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Fields that the request kind ignores carry random values
    task automatic load_point(input logic [FIELD_W-1:0] c);
        send_req(sipj_pkg::KIND_LOAD, c, $urandom, $urandom, MOTIF_W'($urandom));
    endtask

    task automatic query_interval(input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi,
                                  input logic [MOTIF_W-1:0] m);
        send_req(sipj_pkg::KIND_QUERY, $urandom, lo, hi, m);
    endtask

    task automatic new_chrom();
        send_req(sipj_pkg::KIND_NEW_CHROM, $urandom, $urandom, $urandom, MOTIF_W'($urandom));
    endtask

    task automatic clear_counts();
        send_req(sipj_pkg::KIND_CLEAR_CNT, $urandom, $urandom, $urandom, MOTIF_W'($urandom));
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (expected_hits.size() != 0);
    endtask

    function automatic logic [MOTIF_W-1:0] pick_motif();
        case ($urandom_range(0, 4))
            0: return 10'd0;
            1: return 10'd1023;
            2: return 10'd37;
            default: return MOTIF_W'($urandom_range(0, NUM_MOTIFS - 1));
        endcase
    endfunction

    task automatic send_noise();
        case ($urandom_range(0, 19))
            0: clear_counts();
            1: new_chrom();
            2, 3, 4, 5, 6, 7, 8: load_point($urandom);
            default: query_interval($urandom, $urandom, MOTIF_W'($urandom));
        endcase
    endtask

    // One chromosome: sorted loads, then queries with ascending starts
    task automatic run_sweep();
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] coord;
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
        int                 n_pts;
        int                 n_q;
        n_pts = $urandom_range(0, 16);
        n_q   = $urandom_range(1, 6);
        base  = $urandom_range(0, 32'hFFFF_F000);
        new_chrom();
        coord = base;
        for (int i = 0; i < n_pts; i++)
        begin
            coord = coord + $urandom_range(0, 12);
            if ($urandom_range(0, 9) == 0)
                send_noise();
            load_point(coord);
        end
        lo = base;
        for (int j = 0; j < n_q; j++)
        begin
            lo = lo + $urandom_range(0, 40);
            hi = lo + $urandom_range(0, 60);
            if ($urandom_range(0, 9) == 0)
                hi = lo - $urandom_range(1, 8);
            if ($urandom_range(0, 9) == 0)
                send_noise();
            query_interval(lo, hi, pick_motif());
        end
    endtask

    task automatic test_directed_cases();
        // empty store right after reset
        query_interval(32'd10, 32'd20, 10'd5);
        load_point(32'd0);
        load_point(32'd1);
        load_point(32'd5);
        load_point(32'd5);
        load_point(32'd9);
        load_point(32'h8000_0000);
        load_point(32'hFFFF_FFFE);
        load_point(32'hFFFF_FFFF);
        query_interval(32'd0, 32'd0, 10'd0);
        query_interval(32'd1, 32'd5, 10'd1023);
        query_interval(32'd6, 32'd8, 10'd1023);
        // begin above end
        query_interval(32'd7, 32'd6, 10'd512);
        // kept pointer: the points at 5 are not visited again
        query_interval(32'd5, 32'd9, 10'd0);
        query_interval(32'h8000_0000, 32'hFFFF_FFFE, 10'd0);
        query_interval(32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd341);
        query_interval(32'd0, 32'hFFFF_FFFF, 10'd682);
        clear_counts();
        query_interval(32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023);
        new_chrom();
        load_point(32'd100);
        // every point below the start: pointer stops at the count
        query_interval(32'd200, 32'd300, 10'd341);
        load_point(32'd250);
        query_interval(32'd200, 32'd300, 10'd1023);
        // unsorted load behind the pointer
        load_point(32'd50);
        query_interval(32'd0, 32'd100, 10'd682);
    endtask

    task automatic test_hit_limit();
        new_chrom();
        for (int i = 0; i <= MAX_HITS; i++)
            load_point(32'(4000 + i * 4));
        // exactly MAX_HITS points in range, then one more than that
        query_interval(32'd4000, 32'd4252, 10'd1023);
        query_interval(32'd4000, 32'd4256, 10'd0);
        query_interval(32'd4256, 32'd4256, 10'd37);
        new_chrom();
    endtask

    task automatic test_output_hold_off();
        new_chrom();
        for (int i = 0; i < 8; i++)
            load_point(32'(1000 + 3 * i));
        hold_cycles = HOLD_OFF;
        for (int j = 0; j < 6; j++)
            query_interval(32'(1000 + 6 * j), 32'(1008 + 6 * j), MOTIF_W'(j * 85));
        wait_drained();
        query_interval(32'd990, 32'd1100, 10'd85);
    endtask

    task automatic test_random_sweeps();
        int unsigned start;
        start = reqs_sent;
        while (reqs_sent - start < RANDOM_REQS)
        begin
            run_sweep();
            if ($urandom_range(0, 2) == 0)
                wait_drained();
        end
    endtask

    task automatic test_quiet_tail();
        idle_on = 1'b0;
        run_sweep();
    endtask

    initial
    begin
        wipe_motif_counts();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_hit_limit();
        test_output_hold_off();
        test_random_sweeps();
        test_quiet_tail();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request
    initial
    begin : drive_res_ready
        int unsigned gap;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles != 0)
            begin
                gap         = hold_cycles;
                hold_cycles = 0;
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(posedge clk);
            end
            else
                res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        join_result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_hits.size() == 0)
                report_mismatch("result with nothing pending", 32'(point_index), 32'd0);
            else
            begin
                want = expected_hits.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", 32'(hit), 32'(want.hit));
                if (point_index !== want.idx)
                    report_mismatch("point_index", 32'(point_index), 32'(want.idx));
                if (point_coord_out !== want.coord)
                    report_mismatch("point_coord_out", point_coord_out, want.coord);
                if (motif_out !== want.motif)
                    report_mismatch("motif_out", 32'(motif_out), 32'(want.motif));
                if (motif_hits !== want.count)
                    report_mismatch("motif_hits", motif_hits, want.count);
                if (last !== want.is_last)
                    report_mismatch("last", 32'(last), 32'(want.is_last));
                if (truncated !== want.trunc)
                    report_mismatch("truncated", 32'(truncated), 32'(want.trunc));
                if (load_overflow !== want.ovf)
                    report_mismatch("load_overflow", 32'(load_overflow), 32'(want.ovf));
            end
        end
    end

    // Drop the run if no request and no result moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (res_valid && res_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= STUCK_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

[filelist.f]
rtl/core/sipj_pkg.sv
rtl/core/sipj_ram.sv
rtl/core/sorted_interval_point_join_core.sv
tb/tb_sorted_interval_point_join_core.sv
